FILE: rtl/dwcsm_pkg.sv
// ----------------------------------------------------------------------------
// dwcsm_pkg: shared definitions for the dual-width caseless string matcher
// Register indexes, field widths and the case folding used by both views.
// ----------------------------------------------------------------------------
`default_nettype none

package dwcsm_pkg;

	localparam int MAX_PATTERN_CHARS = 16;

	localparam int CHAR_W         = 16;
	localparam int CHARS_PER_REG  = 4;
	localparam int CFG_W          = CHAR_W * CHARS_PER_REG;
	localparam int CFG_IDX_W      = 3;
	localparam int LEN_FIELD_W    = 5;
	localparam int DATA_W         = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CHARS_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

	// Only ASCII upper-case letters are folded; all other codes pass unchanged.
	function automatic logic [7:0] fold8(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] fold16(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c inside {[16'h0041:16'h005A]}) begin
			r = c + 16'h0020;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dwcsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// dwcsm_cfg_regs: pattern and length registers
// Unpacks the 64-bit character registers into per-character storage and keeps
// the pattern length clamped to the number of characters the block holds.
// ----------------------------------------------------------------------------
`default_nettype none

module dwcsm_cfg_regs #(
	parameter int MAX_PATTERN_CHARS = dwcsm_pkg::MAX_PATTERN_CHARS,
	localparam int LW = $clog2(MAX_PATTERN_CHARS + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [dwcsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dwcsm_pkg::CFG_W-1:0]         cfg_data,
	output logic      [dwcsm_pkg::CHAR_W-1:0]        pat [MAX_PATTERN_CHARS],
	output logic      [LW-1:0]                       len
);

	logic [LW-1:0] len_q;

	for (genvar c = 0; c < MAX_PATTERN_CHARS; c++) begin : g_char
		localparam logic [dwcsm_pkg::CFG_IDX_W-1:0] RegIdx =
			dwcsm_pkg::CFG_IDX_W'(c / dwcsm_pkg::CHARS_PER_REG);
		localparam int Lsb = (c % dwcsm_pkg::CHARS_PER_REG) * dwcsm_pkg::CHAR_W;
		logic [dwcsm_pkg::CHAR_W-1:0] char_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				char_q <= '0;
			end else if (cfg_we && cfg_index == RegIdx) begin
				char_q <= cfg_data[Lsb +: dwcsm_pkg::CHAR_W];
			end
		end

		assign pat[c] = char_q;
	end

	// Lengths beyond the stored characters behave as the full pattern.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_we && cfg_index == dwcsm_pkg::REG_LENGTH) begin
			if (cfg_data[dwcsm_pkg::LEN_FIELD_W-1:0] >
			    dwcsm_pkg::LEN_FIELD_W'(MAX_PATTERN_CHARS)) begin
				len_q <= LW'(MAX_PATTERN_CHARS);
			end else begin
				len_q <= cfg_data[LW-1:0];
			end
		end
	end

	assign len = len_q;

endmodule

`default_nettype wire

FILE: rtl/dwcsm_window_cmp.sv
// ----------------------------------------------------------------------------
// dwcsm_window_cmp: parallel window compare
// Tests the pattern against the newest bytes of the history, both as bytes and
// as little-endian 16-bit units, for every possible length, then selects the
// configured length.
// ----------------------------------------------------------------------------
`default_nettype none

module dwcsm_window_cmp #(
	parameter int MAX_PATTERN_CHARS = dwcsm_pkg::MAX_PATTERN_CHARS,
	localparam int LW    = $clog2(MAX_PATTERN_CHARS + 1),
	localparam int DEPTH = 2 * MAX_PATTERN_CHARS,
	localparam int SW    = $clog2(DEPTH + 1)
) (
	input  wire logic [dwcsm_pkg::DATA_W-1:0] hist [DEPTH],
	input  wire logic [dwcsm_pkg::CHAR_W-1:0] pat  [MAX_PATTERN_CHARS],
	input  wire logic [LW-1:0]                len,
	input  wire logic [SW-1:0]                seen,
	input  wire logic                         wide_en,
	output logic                              hit
);

	logic byte_hit [MAX_PATTERN_CHARS + 1];
	logic wide_hit [MAX_PATTERN_CHARS + 1];

	always_comb begin
		logic b_ok;
		logic w_ok;
		// An empty pattern is found in every file.
		byte_hit[0] = 1'b1;
		wide_hit[0] = 1'b1;
		for (int l = 1; l <= MAX_PATTERN_CHARS; l++) begin
			b_ok = 1'b1;
			w_ok = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (pat[i][dwcsm_pkg::CHAR_W-1:8] != '0) begin
					b_ok = 1'b0;
				end
				if (dwcsm_pkg::fold8(hist[l-1-i]) != dwcsm_pkg::fold8(pat[i][7:0])) begin
					b_ok = 1'b0;
				end
				// The newer byte of a unit is its high byte.
				if (dwcsm_pkg::fold16({hist[2*(l-1-i)], hist[2*(l-1-i)+1]}) !=
				    dwcsm_pkg::fold16(pat[i])) begin
					w_ok = 1'b0;
				end
			end
			byte_hit[l] = b_ok && (seen >= SW'(l));
			wide_hit[l] = w_ok && (seen >= SW'(2 * l));
		end
	end

	assign hit = byte_hit[len] || (wide_en && wide_hit[len]);

endmodule

`default_nettype wire

FILE: rtl/dual_width_caseless_string_matcher_unit.sv
// ----------------------------------------------------------------------------
// dual_width_caseless_string_matcher_unit: caseless pattern search over files
// Reports at the last byte of each file whether the pattern occurred in it,
// searched both as bytes and as 16-bit little-endian units.
//
//   channel  dir  width  contents
//   s_*      in   8+1    tdata: data_byte[7:0]; tlast: last_byte
//   m_*      out  8      tdata: matched[0], bits 7:1 zero
//   cfg_*    in   3+64   register index, write data
//
// One byte is taken every cycle unless a pending result stalls the input.
// A byte enters the history shift line on acceptance; in the next cycle the
// window compare runs between the history and the stage-1 register, and the
// result of a last byte lands in the output register.
// Reset clears the pattern, the file counters and both valid flags.
// A pending result only stalls the input when a second last byte must wait.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_width_caseless_string_matcher_unit #(
	parameter int MAX_PATTERN_CHARS = dwcsm_pkg::MAX_PATTERN_CHARS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [dwcsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dwcsm_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,   // data_byte[7:0]
	input  wire logic                              s_tlast,   // last_byte
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [7:0]                        m_tdata    // matched[0], zero above
);

	localparam int LW    = $clog2(MAX_PATTERN_CHARS + 1);
	localparam int DEPTH = 2 * MAX_PATTERN_CHARS;
	localparam int SW    = $clog2(DEPTH + 1);

	logic [dwcsm_pkg::CHAR_W-1:0] pat [MAX_PATTERN_CHARS];
	logic [LW-1:0]                len;

	logic [dwcsm_pkg::DATA_W-1:0] hist_q [DEPTH];
	logic [SW-1:0]                seen_q;
	logic [SW-1:0]                seen_nx;
	logic                         odd_q;
	logic                         match_q;

	logic                         valid_s1;
	logic                         last_s1;
	logic                         wide_s1;
	logic [SW-1:0]                seen_s1;

	logic                         out_valid_q;
	logic                         matched_q;

	logic                         s_accept;
	logic                         adv_s1;
	logic                         hit;

	dwcsm_cfg_regs #(
		.MAX_PATTERN_CHARS(MAX_PATTERN_CHARS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pat      (pat),
		.len      (len)
	);

	dwcsm_window_cmp #(
		.MAX_PATTERN_CHARS(MAX_PATTERN_CHARS)
	) u_cmp (
		.hist   (hist_q),
		.pat    (pat),
		.len    (len),
		.seen   (seen_s1),
		.wide_en(wide_s1),
		.hit    (hit)
	);

	// Only a last byte needs the output register, so others always move on.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_accept = s_tvalid && s_tready;
	assign seen_nx  = (seen_q == SW'(DEPTH)) ? seen_q : seen_q + SW'(1);

	// The history only moves on acceptance, so while an item sits in stage 1
	// the shift line holds exactly the bytes up to and including it.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			hist_q[0] <= s_tdata;
			for (int i = 1; i < DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			odd_q  <= 1'b0;
		end else if (s_accept) begin
			seen_q <= s_tlast ? '0 : seen_nx;
			odd_q  <= s_tlast ? 1'b0 : !odd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			last_s1 <= s_tlast;
			wide_s1 <= odd_q;
			seen_s1 <= seen_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (adv_s1) begin
			match_q <= last_s1 ? 1'b0 : (match_q || hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			matched_q <= match_q || hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, matched_q};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_file_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tlast) |=> (seen_q == '0 && !odd_q))
		else $error("file counters not cleared after last byte");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result raised without a last byte in stage 1");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SW'(DEPTH))
		else $error("byte count beyond history depth");

	a_match_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> !match_q)
		else $error("match flag kept across files");

endmodule

`default_nettype wire
